// ----- rtl/lir_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths and constants of the linear interpolation resampler.
package lir_pkg;

  localparam int SAMPLE_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int CNT_W        = $clog2(SAMPLE_DEPTH + 1);
  localparam int SAMPLE_W     = 16;
  localparam int RATE_W       = 18;
  localparam int IDX_W        = 30;
  localparam int CFG_IDX_W    = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = CFG_IDX_W'(1);

  localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = RATE_W'(16000);

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Shared multiplier and divider widths
  localparam int MUL_A_W   = IDX_W + 1;
  localparam int MUL_B_W   = RATE_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_W     = IDX_W + RATE_W;
  localparam int DVS_W     = RATE_W + 1;
  localparam int STEP_W    = $clog2(DIV_W + 1);
  localparam int CNT_DIV_W = CNT_W + RATE_W + 1;
  localparam int NUM_W     = SAMPLE_W + RATE_W + 2;

endpackage

// ----- rtl/lir_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/linear_interp_resampler.sv -----
`timescale 1ns / 1ps
// Linear interpolation resampler. Throughput: one transaction at a time, the next taken the cycle
// after the result is registered; set by the shared restoring divider, one quotient bit a cycle.
// Reset (synchronous, active high): empty the buffer, clear input_rate, set output_rate to
// 16000 and drop any pending result; the sample RAM itself is not cleared.
module linear_interp_resampler
  import lir_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // request channel
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       op,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [IDX_W-1:0]           out_index,
  // response channel
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic [IDX_W-1:0]           output_count,
  output logic                       index_valid,
  output logic                       sample_dropped,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [RATE_W-1:0]          cfg_data
);

  // Sequencer states, one-hot
  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_CMUL  = 17'h00002,
    ST_CLOAD = 17'h00004,
    ST_CRUN  = 17'h00008,
    ST_CFIN  = 17'h00010,
    ST_CHK   = 17'h00020,
    ST_PRD   = 17'h00040,
    ST_LLOAD = 17'h00080,
    ST_LRUN  = 17'h00100,
    ST_RDL   = 17'h00200,
    ST_RDR   = 17'h00400,
    ST_IMUL1 = 17'h00800,
    ST_IMUL2 = 17'h01000,
    ST_ILOAD = 17'h02000,
    ST_IRUN  = 17'h04000,
    ST_IFIN  = 17'h08000,
    ST_DONE  = 17'h10000
  } state_t;

  localparam logic [SAMPLE_W-1:0] SMP_POS_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SMP_NEG_MAX = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [CNT_DIV_W-1:0] CNT_SAT    = CNT_DIV_W'({IDX_W{1'b1}});

  state_t state, state_next;

  // Control state
  logic [CNT_W-1:0]  n_cnt;
  logic [RATE_W-1:0] in_rate;
  logic [RATE_W-1:0] out_rate;

  // Item and working registers
  logic                       op_q;
  logic [IDX_W-1:0]           idx_q;
  logic                       drop_q;
  logic                       valid_q;
  logic [CNT_DIV_W-1:0]       cnt;
  logic signed [PROD_W-1:0]   p;
  logic signed [NUM_W-1:0]    acc;
  logic                       num_neg;
  logic [ADDR_W-1:0]          lidx;
  logic [RATE_W-1:0]          rem;
  logic signed [SAMPLE_W-1:0] l_smp;
  logic signed [SAMPLE_W-1:0] r_smp;
  logic signed [SAMPLE_W-1:0] res_smp;

  // Divider registers: quotient/dividend, partial remainder, divisor, step count
  logic [DIV_W-1:0]  dq;
  logic [DVS_W-1:0]  dr;
  logic [DVS_W-1:0]  dd;
  logic [STEP_W-1:0] step;

  logic req_acc;
  logic out_free;
  logic pass;

  assign req_stall = (state != ST_IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Rates that leave the samples untouched
  assign pass = (n_cnt == '0) || (in_rate == '0) || (out_rate == '0) || (in_rate == out_rate);

  // Last valid buffer slot
  logic [CNT_W-1:0]  n_last;
  logic [ADDR_W-1:0] last;
  assign n_last = n_cnt - CNT_W'(1);
  assign last   = n_last[ADDR_W-1:0];

  // Shared divider step: one restoring quotient bit
  logic [DVS_W:0] shl;
  logic [DVS_W:0] dif;
  logic           take;
  assign shl  = {dr, dq[DIV_W-1]};
  assign dif  = shl - {1'b0, dd};
  assign take = !dif[DVS_W];

  // Shared signed multiplier, operands chosen by state
  logic signed [MUL_A_W-1:0] ma;
  logic signed [MUL_B_W-1:0] mb;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SAMPLE_W:0]  dlt;

  assign dlt = {r_smp[SAMPLE_W-1], r_smp} - {l_smp[SAMPLE_W-1], l_smp};

  always_comb begin
    unique case (state)
      ST_CMUL: begin
        ma = {{(MUL_A_W-CNT_W){1'b0}}, n_cnt};
        mb = {1'b0, out_rate};
      end
      ST_CHK: begin
        ma = {1'b0, idx_q};
        mb = {1'b0, in_rate};
      end
      ST_IMUL1: begin
        ma = {{(MUL_A_W-SAMPLE_W){l_smp[SAMPLE_W-1]}}, l_smp};
        mb = {1'b0, out_rate};
      end
      ST_IMUL2: begin
        ma = {{(MUL_A_W-SAMPLE_W-1){dlt[SAMPLE_W]}}, dlt};
        mb = {1'b0, rem};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // Dividends: rounded count, interpolation numerator
  logic [CNT_DIV_W-1:0]    cdvd;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;
  logic [NUM_W-1:0]        idvd;

  assign cdvd = {p[CNT_DIV_W-2:0], 1'b0} + CNT_DIV_W'(in_rate);
  assign num  = acc + p[NUM_W-1:0];
  assign mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign idvd = {mag[NUM_W-2:0], 1'b0} + NUM_W'(out_rate);

  // Neighbour indexes, clamped to the last buffered sample
  logic [ADDR_W-1:0] left_c;
  logic [ADDR_W-1:0] right_c;
  assign left_c  = (dq > DIV_W'(last)) ? last : dq[ADDR_W-1:0];
  assign right_c = (lidx == last) ? last : lidx + ADDR_W'(1);

  logic idx_lt;
  assign idx_lt = CNT_DIV_W'(idx_q) < cnt;

  // Sample RAM
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign ram_we = req_acc && (op == OP_PUSH) && (n_cnt < CNT_W'(SAMPLE_DEPTH));

  always_comb begin
    unique case (state)
      ST_CHK:  ram_raddr = idx_q[ADDR_W-1:0];
      ST_RDL:  ram_raddr = left_c;
      ST_RDR:  ram_raddr = right_c;
      default: ram_raddr = '0;
    endcase
  end

  lir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n_cnt[ADDR_W-1:0]),
    .wdata (sample_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    unique case (state)
      ST_IDLE:  state_next = req_acc ? ST_CMUL : ST_IDLE;
      ST_CMUL:  state_next = pass ? ST_CHK : ST_CLOAD;
      ST_CLOAD: state_next = ST_CRUN;
      ST_CRUN:  state_next = (step == STEP_W'(1)) ? ST_CFIN : ST_CRUN;
      ST_CFIN:  state_next = ST_CHK;
      ST_CHK: begin
        if (op_q == OP_PUSH || !idx_lt) begin
          state_next = ST_DONE;
        end else if (pass) begin
          state_next = ST_PRD;
        end else begin
          state_next = ST_LLOAD;
        end
      end
      ST_PRD:   state_next = ST_DONE;
      ST_LLOAD: state_next = ST_LRUN;
      ST_LRUN:  state_next = (step == STEP_W'(1)) ? ST_RDL : ST_LRUN;
      ST_RDL:   state_next = ST_RDR;
      ST_RDR:   state_next = ST_IMUL1;
      ST_IMUL1: state_next = ST_IMUL2;
      ST_IMUL2: state_next = ST_ILOAD;
      ST_ILOAD: state_next = ST_IRUN;
      ST_IRUN:  state_next = (step == STEP_W'(1)) ? ST_IFIN : ST_IRUN;
      ST_IFIN:  state_next = ST_DONE;
      ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control state, configuration and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      n_cnt     <= '0;
      in_rate   <= '0;
      out_rate  <= OUTPUT_RATE_RST;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        n_cnt <= n_cnt + CNT_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_INPUT_RATE:  in_rate  <= cfg_data;
          REG_OUTPUT_RATE: out_rate <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          op_q   <= op;
          idx_q  <= out_index;
          drop_q <= (op == OP_PUSH) && !ram_we;
        end
      end
      ST_CMUL: begin
        p <= prod;
        if (pass) begin
          cnt <= CNT_DIV_W'(n_cnt);
        end
      end
      ST_CLOAD: begin
        // round(N*out/in) as (2*N*out + in) / (2*in)
        dq   <= {cdvd, {(DIV_W-CNT_DIV_W){1'b0}}};
        dr   <= '0;
        dd   <= {in_rate, 1'b0};
        step <= STEP_W'(CNT_DIV_W);
      end
      ST_CFIN: begin
        cnt <= (dq[CNT_DIV_W-1:0] == '0) ? CNT_DIV_W'(1) : dq[CNT_DIV_W-1:0];
      end
      ST_CHK: begin
        p       <= prod;
        valid_q <= (op_q == OP_READ) && idx_lt;
        res_smp <= '0;
      end
      ST_PRD: begin
        res_smp <= ram_rdata;
      end
      ST_LLOAD: begin
        // left = i*in / out, remainder kept for the weight
        dq   <= p[DIV_W-1:0];
        dr   <= '0;
        dd   <= {1'b0, out_rate};
        step <= STEP_W'(DIV_W);
      end
      ST_RDL: begin
        lidx <= left_c;
        rem  <= dr[RATE_W-1:0];
      end
      ST_RDR: begin
        l_smp <= ram_rdata;
      end
      ST_IMUL1: begin
        r_smp <= ram_rdata;
        p     <= prod;
      end
      ST_IMUL2: begin
        acc <= p[NUM_W-1:0];
        p   <= prod;
      end
      ST_ILOAD: begin
        // round half away from zero: (2*|num| + out) / (2*out), sign restored after
        num_neg <= num[NUM_W-1];
        dq      <= {idvd, {(DIV_W-NUM_W){1'b0}}};
        dr      <= '0;
        dd      <= {out_rate, 1'b0};
        step    <= STEP_W'(NUM_W);
      end
      ST_IFIN: begin
        if (!num_neg) begin
          res_smp <= (dq > DIV_W'(SMP_POS_MAX)) ? SMP_POS_MAX : dq[SAMPLE_W-1:0];
        end else begin
          res_smp <= (dq > DIV_W'(SMP_NEG_MAX)) ? SMP_NEG_MAX : -dq[SAMPLE_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          sample_out     <= res_smp;
          output_count   <= (cnt > CNT_SAT) ? {IDX_W{1'b1}} : cnt[IDX_W-1:0];
          index_valid    <= valid_q;
          sample_dropped <= drop_q;
        end
      end
      default: ;
    endcase

    // One divider step in every run state
    if (state == ST_CRUN || state == ST_LRUN || state == ST_IRUN) begin
      dq   <= {dq[DIV_W-2:0], take};
      dr   <= take ? dif[DVS_W-1:0] : shl[DVS_W-1:0];
      step <= step - STEP_W'(1);
    end
  end

endmodule

// ----- rtl/lir_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the linear interpolation resampler, with its bind.
module lir_chk
  import lir_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_stall,
  input logic                       rsp_valid,
  input logic                       rsp_stall,
  input logic signed [SAMPLE_W-1:0] sample_out,
  input logic [IDX_W-1:0]           output_count,
  input logic                       index_valid,
  input logic                       sample_dropped
);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(sample_out) &&
      $stable(output_count) && $stable(index_valid) && $stable(sample_dropped))
    else $error("stalled response changed");

  // Busy right after taking a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while still working");

  // Drop a push or invalid read to a zero sample
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !index_valid |-> sample_out == '0)
    else $error("non-zero sample without a valid index");

  // A dropped push never reports a valid read
  a_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && sample_dropped |-> !index_valid)
    else $error("dropped push flagged as valid read");

  // A valid index implies a non-empty output
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && index_valid |-> output_count != '0)
    else $error("valid index with zero output count");

endmodule

bind linear_interp_resampler lir_chk u_lir_chk (.*);
